// ===== hw/rtl/pool2d_pkg.sv =====
package pool2d_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE_AVERAGE = 3'd0,
    REG_NUM_ROWS     = 3'd1,
    REG_NUM_COLS     = 3'd2,
    REG_FILTER_ROWS  = 3'd3,
    REG_FILTER_COLS  = 3'd4,
    REG_STRIDE       = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_OUTPUT
  } back_state_t;

  localparam logic signed [7:0] ELEM_LOWEST = -8'sd128;

endpackage

// ===== hw/rtl/pool2d_ram.sv =====
module pool2d_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/pool2d_front.sv =====
module pool2d_front #(
  parameter int MaxDim = 64,
  parameter int MaxFilter = 8,
  parameter int DimW = $clog2(MaxDim),
  parameter int FiltW = $clog2(MaxFilter + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [DimW:0]    rows,
  input  logic [DimW:0]    cols,
  input  logic [FiltW-1:0] fr,
  input  logic [FiltW-1:0] fc,
  input  logic [3:0]       st,
  output logic [DimW-1:0]  wr_row,
  output logic [DimW-1:0]  wr_col,
  output logic             job_valid,
  output logic [DimW-1:0]  job_r0,
  output logic [DimW-1:0]  job_c0,
  output logic [DimW-1:0]  job_oi,
  output logic [DimW-1:0]  job_oj,
  output logic             job_last
);

  // Row and column phase counters stand in for modulo by the stride.
  logic [DimW-1:0] row_count, col_count;
  logic [DimW-1:0] oi, oj;
  logic [3:0]      rph, cph;
  logic [DimW:0]   dr, dc;
  logic            row_hit, col_hit, row_in, col_in;
  logic [DimW:0]   span_r, span_c;

  assign wr_row = row_count;
  assign wr_col = col_count;

  assign dr = {1'b0, row_count} + 1'b1 - (DimW+1)'(fr);
  assign dc = {1'b0, col_count} + 1'b1 - (DimW+1)'(fc);
  assign span_r = rows - (DimW+1)'(fr);
  assign span_c = cols - (DimW+1)'(fc);
  assign row_in = (rows >= (DimW+1)'(fr)) && ({1'b0, row_count} + 1'b1 >= (DimW+1)'(fr));
  assign col_in = (cols >= (DimW+1)'(fc)) && ({1'b0, col_count} + 1'b1 >= (DimW+1)'(fc));
  assign row_hit = row_in && (rph == 4'd0) && (dr <= span_r);
  assign col_hit = col_in && (cph == 4'd0) && (dc <= span_c);

  logic acc;
  assign acc = in_valid && in_ready;

  logic [DimW:0] nr_r, nr_c;
  assign nr_r = dr + (DimW+1)'(st);
  assign nr_c = dc + (DimW+1)'(st);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_count <= '0;
      col_count <= '0;
      rph <= '0;
      cph <= '0;
      oi <= '0;
      oj <= '0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= 1'b0;
      if (acc) begin
        job_valid <= row_hit && col_hit;
        job_r0 <= dr[DimW-1:0];
        job_c0 <= dc[DimW-1:0];
        job_oi <= oi;
        job_oj <= oj;
        job_last <= (nr_r > span_r) && (nr_c > span_c);
        if ({1'b0, col_count} + 1'b1 >= cols) begin
          col_count <= '0;
          cph <= '0;
          oj <= '0;
          if ({1'b0, row_count} + 1'b1 >= rows) begin
            row_count <= '0;
            rph <= '0;
            oi <= '0;
          end else begin
            row_count <= row_count + 1'b1;
            if (row_in) begin
              if (rph + 4'd1 >= st) begin
                rph <= '0;
                oi <= oi + 1'b1;
              end else begin
                rph <= rph + 4'd1;
              end
            end
          end
        end else begin
          col_count <= col_count + 1'b1;
          if (col_in) begin
            if (cph + 4'd1 >= st) begin
              cph <= '0;
              oj <= oj + 1'b1;
            end else begin
              cph <= cph + 4'd1;
            end
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/pool2d_back.sv =====
module pool2d_back #(
  parameter int MaxDim = 64,
  parameter int MaxFilter = 8,
  parameter int DimW = $clog2(MaxDim),
  parameter int FiltW = $clog2(MaxFilter + 1),
  parameter int AddrW = 2 * DimW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              mode_average,
  input  logic [FiltW-1:0]  fr,
  input  logic [FiltW-1:0]  fc,
  input  logic              job_valid,
  output logic              job_ready,
  input  logic [DimW-1:0]   job_r0,
  input  logic [DimW-1:0]   job_c0,
  input  logic [DimW-1:0]   job_oi,
  input  logic [DimW-1:0]   job_oj,
  input  logic              job_last,
  output logic [AddrW-1:0]  rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] pooled_value,
  output logic [DimW-1:0]   out_row,
  output logic [DimW-1:0]   out_col,
  output logic              frame_last
);

  localparam int SumW = 8 + 2 * FiltW;
  localparam int AreaW = 2 * FiltW;

  pool2d_pkg::back_state_t state, state_next;

  logic [DimW-1:0]  r0, c0;
  logic [FiltW-1:0] k, m;
  logic             rd_pend, done_rd, last_issue;
  logic signed [SumW-1:0] sum;
  logic signed [7:0] best;
  logic signed [7:0] v;
  logic [AreaW-1:0] area;
  logic [SumW-1:0]  quo, rem;
  logic [$clog2(SumW+1)-1:0] bitc;
  logic neg;
  logic [SumW:0] trial;

  assign v = rd_data;
  assign area = AreaW'(fr) * AreaW'(fc);
  assign rd_addr = {r0 + DimW'(k), c0 + DimW'(m)};
  assign last_issue = (k == fr - 1'b1) && (m == fc - 1'b1);
  assign trial = {rem, quo[SumW-1]} - (SumW+1)'(area);

  always_comb begin
    state_next = state;
    unique case (state)
      pool2d_pkg::ST_IDLE:   if (job_valid) state_next = pool2d_pkg::ST_READ;
      pool2d_pkg::ST_READ:   if (done_rd && !rd_pend) state_next = pool2d_pkg::ST_DIVIDE;
      pool2d_pkg::ST_DIVIDE: if (bitc == '0) state_next = pool2d_pkg::ST_OUTPUT;
      pool2d_pkg::ST_OUTPUT: if (out_ready) state_next = pool2d_pkg::ST_IDLE;
      default:               state_next = pool2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == pool2d_pkg::ST_IDLE);
    out_valid = (state == pool2d_pkg::ST_OUTPUT);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= pool2d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      rd_pend <= 1'b0;
      done_rd <= 1'b0;
    end else begin
      unique case (state)
        pool2d_pkg::ST_IDLE: begin
          if (job_valid) begin
            r0 <= job_r0;
            c0 <= job_c0;
            out_row <= job_oi;
            out_col <= job_oj;
            frame_last <= job_last;
            k <= '0;
            m <= '0;
            sum <= '0;
            best <= pool2d_pkg::ELEM_LOWEST;
            rd_pend <= 1'b0;
            done_rd <= 1'b0;
          end
        end
        pool2d_pkg::ST_READ: begin
          rd_pend <= !done_rd;
          if (rd_pend) begin
            sum <= sum + SumW'(v);
            if (v > best) best <= v;
          end
          if (!done_rd) begin
            if (last_issue) begin
              done_rd <= 1'b1;
            end else if (m == fc - 1'b1) begin
              m <= '0;
              k <= k + 1'b1;
            end else begin
              m <= m + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Restoring division of the magnitude, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (state == pool2d_pkg::ST_READ) begin
      neg <= sum[SumW-1];
      quo <= sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
      rem <= '0;
      bitc <= ($clog2(SumW+1))'(SumW);
      if (rd_pend) begin
        neg <= (sum + SumW'(v)) < 0;
        quo <= ((sum + SumW'(v)) < 0) ? SumW'(-(sum + SumW'(v))) : SumW'(sum + SumW'(v));
      end
    end else if (state == pool2d_pkg::ST_DIVIDE && bitc != '0) begin
      bitc <= bitc - 1'b1;
      if (!trial[SumW]) begin
        rem <= trial[SumW-1:0];
        quo <= {quo[SumW-2:0], 1'b1};
      end else begin
        rem <= {rem[SumW-2:0], quo[SumW-1]};
        quo <= {quo[SumW-2:0], 1'b0};
      end
    end
  end

  logic signed [SumW:0] q_s;
  always_comb begin
    q_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (!mode_average) pooled_value = best;
    else if (q_s > 127) pooled_value = 8'sd127;
    else if (q_s < -128) pooled_value = -8'sd128;
    else pooled_value = q_s[7:0];
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !restart |=> out_valid && $stable(pooled_value))
    else $error("result changed while stalled");
  a_nojob: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> !out_valid)
    else $error("ready to take a job while a result waits");
  a_div: assert property (@(posedge clk) disable iff (rst)
    state == pool2d_pkg::ST_DIVIDE |-> bitc <= SumW)
    else $error("divide counter out of range");

endmodule

// ===== hw/rtl/pooling_2d_int8.sv =====
// Streaming 2-D max or average pooling over a signed 8-bit matrix.
// Elements enter on element/in_valid/in_ready in row-major order and are
// stored in a frame memory. When an element completes a pooling window, a
// job enters a two-entry queue; the back end reads the window from the memory,
// one element a cycle, and divides the sum by the window area one quotient
// bit a cycle. Results leave on out_valid/out_ready with pooled_value,
// out_row, out_col and frame_last. Configuration writes use cfg_valid and
// cfg_ready, which is always high, with cfg_index and cfg_data.
// With the back end idle, the job of the item that completes a window
// passes the front end's job register and the queue; the back end then
// reads the window and runs the divider, which runs in both modes, before
// out_valid rises. The back end takes the next job in the cycle after
// its result leaves, so a window holds it through read, divide and stalls.
// Items that complete no window are taken one a cycle while the queue has
// room; the first item of a frame waits until every window of the previous
// frame has left the back end, so that it cannot overwrite them.
// Reset (rst, synchronous) restores default registers and restarts the
// frame; the memory is not cleared. Any configuration write restarts the
// frame. When the receiver stalls, the result holds, the queue fills and
// in_ready drops.
module pooling_2d_int8 #(
  parameter int MaxDim = 64,
  parameter int MaxFilter = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pool2d_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pool2d_pkg::CfgDataW-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [7:0]               element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [7:0]               pooled_value,
  output logic [5:0]                      out_row,
  output logic [5:0]                      out_col,
  output logic                            frame_last
);

  localparam int DimW = $clog2(MaxDim);
  localparam int FiltW = $clog2(MaxFilter + 1);
  localparam int AddrW = 2 * DimW;
  localparam int QDepth = 2;
  localparam int JobW = 4 * DimW + 1;

  logic       mode_average;
  logic [6:0] num_rows, num_cols;
  logic [3:0] filter_rows, filter_cols, stride;
  logic       cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_average <= 1'b0;
      num_rows <= 7'd8;
      num_cols <= 7'd8;
      filter_rows <= 4'd2;
      filter_cols <= 4'd2;
      stride <= 4'd2;
    end else if (cfg_acc) begin
      unique case (cfg_index)
        pool2d_pkg::REG_MODE_AVERAGE: mode_average <= cfg_data[0];
        pool2d_pkg::REG_NUM_ROWS:     num_rows <= cfg_data[6:0];
        pool2d_pkg::REG_NUM_COLS:     num_cols <= cfg_data[6:0];
        pool2d_pkg::REG_FILTER_ROWS:  filter_rows <= cfg_data[3:0];
        pool2d_pkg::REG_FILTER_COLS:  filter_cols <= cfg_data[3:0];
        pool2d_pkg::REG_STRIDE:       stride <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [DimW:0]    rows, cols;
  logic [FiltW-1:0] fr, fc;
  logic [3:0]       st;

  assign rows = (num_rows == 0) ? (DimW+1)'(1) :
                (num_rows > MaxDim) ? (DimW+1)'(MaxDim) : (DimW+1)'(num_rows);
  assign cols = (num_cols == 0) ? (DimW+1)'(1) :
                (num_cols > MaxDim) ? (DimW+1)'(MaxDim) : (DimW+1)'(num_cols);
  assign fr = (filter_rows == 0) ? FiltW'(1) :
              (filter_rows > MaxFilter) ? FiltW'(MaxFilter) : FiltW'(filter_rows);
  assign fc = (filter_cols == 0) ? FiltW'(1) :
              (filter_cols > MaxFilter) ? FiltW'(MaxFilter) : FiltW'(filter_cols);
  assign st = (stride == 0) ? 4'd1 : stride;

  logic [DimW-1:0] wr_row, wr_col, j_r0, j_c0, j_oi, j_oj;
  logic            j_valid, j_last;
  logic [1:0]      q_cnt;
  logic            q_wp, q_rp;
  logic [JobW-1:0] q_mem [QDepth];
  logic            bk_ready, bk_valid;
  logic [JobW-1:0] q_head;
  logic            frame_start, win_busy;

  assign frame_start = (wr_row == '0) && (wr_col == '0);
  assign win_busy = j_valid || (q_cnt != 2'd0) || !bk_ready;

  // A job is registered in the cycle after its element is taken, so a pending job counts as a taken slot.
  assign in_ready = ((q_cnt == 2'd0) || (q_cnt == 2'd1 && !j_valid)) &&
                    !(frame_start && win_busy);

  pool2d_front #(.MaxDim(MaxDim), .MaxFilter(MaxFilter)) u_front (
    .clk, .rst, .restart(cfg_acc), .in_valid, .in_ready,
    .rows, .cols, .fr, .fc, .st, .wr_row, .wr_col,
    .job_valid(j_valid), .job_r0(j_r0), .job_c0(j_c0),
    .job_oi(j_oi), .job_oj(j_oj), .job_last(j_last)
  );

  assign bk_valid = (q_cnt != 2'd0);
  assign q_head = q_mem[q_rp];

  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      q_cnt <= '0;
      q_wp <= 1'b0;
      q_rp <= 1'b0;
    end else begin
      if (j_valid) begin
        q_mem[q_wp] <= {j_r0, j_c0, j_oi, j_oj, j_last};
        q_wp <= ~q_wp;
      end
      if (bk_valid && bk_ready) q_rp <= ~q_rp;
      q_cnt <= q_cnt + 2'(j_valid) - 2'(bk_valid && bk_ready);
    end
  end

  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;

  pool2d_ram #(.Width(8), .Depth(MaxDim * MaxDim)) u_ram (
    .clk, .wr_en(in_valid && in_ready), .wr_addr({wr_row, wr_col}),
    .wr_data(element), .rd_addr, .rd_data
  );

  logic [DimW-1:0] o_row, o_col;

  pool2d_back #(.MaxDim(MaxDim), .MaxFilter(MaxFilter)) u_back (
    .clk, .rst, .restart(cfg_acc), .mode_average, .fr, .fc,
    .job_valid(bk_valid), .job_ready(bk_ready),
    .job_r0(q_head[4*DimW -: DimW]), .job_c0(q_head[3*DimW -: DimW]),
    .job_oi(q_head[2*DimW -: DimW]), .job_oj(q_head[DimW -: DimW]),
    .job_last(q_head[0]), .rd_addr, .rd_data,
    .out_valid, .out_ready, .pooled_value,
    .out_row(o_row), .out_col(o_col), .frame_last
  );

  assign out_row = 6'(o_row);
  assign out_col = 6'(o_col);

  a_qov: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 2'd2)
    else $error("job queue overflow");
  a_qin: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> q_cnt != 2'd2)
    else $error("item taken with a full queue");
  a_qdrain: assert property (@(posedge clk) disable iff (rst)
    q_cnt == 2'd0 && !cfg_acc |=> !(bk_valid && bk_ready && !$past(j_valid)))
    else $error("job taken from an empty queue");

endmodule

// ===== verif/tb_pooling_2d_int8.sv =====
module tb_pooling_2d_int8;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDim = 64;
  localparam int MaxFilter = 8;
  localparam int DrainCycles = 120;
  localparam int CycleLimit = 3000000;
  localparam logic [2:0] UNUSED_IDX_LO = 3'd6;
  localparam logic [2:0] UNUSED_IDX_HI = 3'd7;
  localparam int NoTyped = 1000;

  typedef struct packed {
    logic signed [7:0] pooled;
    logic [5:0]        row;
    logic [5:0]        col;
    logic              last;
  } window_res_t;

  typedef struct {
    logic signed [7:0] elem;
    bit                avg_setup;
    int                typed;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [7:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic signed [7:0] element = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [7:0] pooled_value;
  logic [5:0]        out_row;
  logic [5:0]        out_col;
  logic              frame_last;

  pooling_2d_int8 dut (.*);

  always #2 clk = ~clk;

  // Predictor state.
  logic signed [7:0] frame_mem [0:MaxDim*MaxDim-1];
  int unsigned       pos_row, pos_col;
  logic              p_mode;
  logic [6:0]        p_rows, p_cols;
  logic [3:0]        p_frows, p_fcols, p_stride;

  window_res_t pending_windows[$];
  int          fails = 0;
  int          cycles = 0;
  int          tx_idle = 0;
  int          rx_idle = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      pool2d_pkg::REG_MODE_AVERAGE: p_mode = val[0];
      pool2d_pkg::REG_NUM_ROWS:     p_rows = val[6:0];
      pool2d_pkg::REG_NUM_COLS:     p_cols = val[6:0];
      pool2d_pkg::REG_FILTER_ROWS:  p_frows = val[3:0];
      pool2d_pkg::REG_FILTER_COLS:  p_fcols = val[3:0];
      pool2d_pkg::REG_STRIDE:       p_stride = val[3:0];
      default: ;
    endcase
    pos_row = 0;
    pos_col = 0;
  endfunction

  function automatic bit pool_window(input logic signed [7:0] e, output window_res_t res);
    int unsigned rows, cols, fr, fc, st, r, c, dr, dc, last_i, last_j, oi, oj;
    int best, sum, v, avg;
    bit hit;
    rows = clampu(p_rows, 1, MaxDim);
    cols = clampu(p_cols, 1, MaxDim);
    fr = clampu(p_frows, 1, MaxFilter);
    fc = clampu(p_fcols, 1, MaxFilter);
    st = clampu(p_stride, 1, 15);
    r = pos_row;
    c = pos_col;
    hit = 0;
    res = '0;
    frame_mem[r*MaxDim + c] = e;
    if (rows >= fr && cols >= fc && r + 1 >= fr && c + 1 >= fc) begin
      dr = r + 1 - fr;
      dc = c + 1 - fc;
      last_i = (rows - fr) / st;
      last_j = (cols - fc) / st;
      if (dr % st == 0 && dc % st == 0 && dr / st <= last_i && dc / st <= last_j) begin
        oi = dr / st;
        oj = dc / st;
        best = -128;
        sum = 0;
        for (int k = 0; k < fr; k++) begin
          for (int m = 0; m < fc; m++) begin
            v = frame_mem[(dr + k)*MaxDim + dc + m];
            sum += v;
            if (v > best) best = v;
          end
        end
        if (p_mode) begin
          avg = sum / int'(fr * fc);
          if (avg > 127) avg = 127;
          if (avg < -128) avg = -128;
        end else begin
          avg = best;
        end
        res.pooled = avg[7:0];
        res.row = oi[5:0];
        res.col = oj[5:0];
        res.last = (oi == last_i && oj == last_j);
        hit = 1;
      end
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    pos_row = r;
    pos_col = c;
    return hit;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_pooling_2d_int8 failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    window_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_windows.size() == 0) begin
        $error("result with nothing expected: pooled_value %0d", pooled_value);
        fails++;
      end else begin
        want = pending_windows.pop_front();
        if (pooled_value !== want.pooled) begin
          $error("pooled_value expected %0d actual %0d", want.pooled, pooled_value);
          fails++;
        end
        if (out_row !== want.row) begin
          $error("out_row expected %0d actual %0d", want.row, out_row);
          fails++;
        end
        if (out_col !== want.col) begin
          $error("out_col expected %0d actual %0d", want.col, out_col);
          fails++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last expected %0d actual %0d", want.last, frame_last);
          fails++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic wait_idle();
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_element(logic signed [7:0] e, int typed);
    window_res_t res;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    element <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (pool_window(e, res)) begin
      if (typed != NoTyped) res.pooled = typed[7:0];
      pending_windows.push_back(res);
    end
  endtask

  task automatic random_phase(logic [7:0] rv[6], int n_items);
    wait_idle();
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? UNUSED_IDX_LO : UNUSED_IDX_HI,
                                          8'($urandom_range(255)));
    write_reg(pool2d_pkg::REG_MODE_AVERAGE, rv[0]);
    write_reg(pool2d_pkg::REG_NUM_ROWS, rv[1]);
    write_reg(pool2d_pkg::REG_NUM_COLS, rv[2]);
    write_reg(pool2d_pkg::REG_FILTER_ROWS, rv[3]);
    write_reg(pool2d_pkg::REG_FILTER_COLS, rv[4]);
    write_reg(pool2d_pkg::REG_STRIDE, rv[5]);
    cfg_valid <= 1'b0;
    for (int i = 0; i < n_items; i++) send_element(8'($urandom_range(255)), NoTyped);
    in_valid <= 1'b0;
  endtask

  stim_row_t directed[24] = '{
    '{8'sd127, 0, NoTyped}, '{-8'sd128, 0, NoTyped}, '{-8'sd128, 0, NoTyped},
    '{-8'sd128, 0, NoTyped}, '{8'sd0, 0, NoTyped}, '{8'sd1, 0, NoTyped},
    '{-8'sd1, 0, NoTyped}, '{8'sd5, 0, NoTyped},
    '{-8'sd128, 0, NoTyped}, '{-8'sd128, 0, 127}, '{-8'sd128, 0, NoTyped},
    '{-8'sd128, 0, -128}, '{8'sd2, 0, NoTyped}, '{8'sd3, 0, NoTyped},
    '{8'sd4, 0, NoTyped}, '{8'sd5, 0, NoTyped},
    '{-8'sd128, 1, NoTyped}, '{-8'sd128, 0, NoTyped}, '{-8'sd128, 0, NoTyped},
    '{-8'sd127, 0, -127},
    '{8'sd127, 0, NoTyped}, '{8'sd127, 0, NoTyped}, '{8'sd127, 0, NoTyped},
    '{8'sd127, 0, 127}
  };

  initial begin
    logic [7:0] rv[6];
    for (int i = 0; i < MaxDim*MaxDim; i++) frame_mem[i] = '0;
    p_mode = 1'b0;
    p_rows = 7'd8;
    p_cols = 7'd8;
    p_frows = 4'd2;
    p_fcols = 4'd2;
    p_stride = 4'd2;
    pos_row = 0;
    pos_col = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].avg_setup) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(pool2d_pkg::REG_MODE_AVERAGE, 8'd1);
        write_reg(pool2d_pkg::REG_NUM_ROWS, 8'd2);
        write_reg(pool2d_pkg::REG_NUM_COLS, 8'd2);
        write_reg(pool2d_pkg::REG_STRIDE, 8'd1);
        cfg_valid <= 1'b0;
      end
      send_element(directed[i].elem, directed[i].typed);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        tx_idle = 34;
        rx_idle = 55;
      end else if (ph < 8) begin
        tx_idle = 55;
        rx_idle = 34;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      case (ph)
        0: rv = '{8'd0, 8'd64, 8'd8, 8'd8, 8'd8, 8'd8};
        1: rv = '{8'd1, 8'd1, 8'd64, 8'd1, 8'd1, 8'd1};
        2: rv = '{8'hFF, 8'hFF, 8'h80, 8'hFF, 8'hF0, 8'hFF};
        default: begin
          rv[0] = 8'($urandom_range(255));
          for (int k = 1; k < 6; k++) begin
            if ($urandom_range(5) == 0) rv[k] = 8'($urandom_range(255));
            else rv[k] = (k < 3) ? 8'($urandom_range(1, 10)) : 8'($urandom_range(1, 4));
          end
        end
      endcase
      random_phase(rv, 78);
    end

    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0 && pending_windows.size() == 0) begin
      $display("tb_pooling_2d_int8 passed");
    end else begin
      $display("tb_pooling_2d_int8 failed");
    end
    $finish;
  end

endmodule
